// File: src/scaled_frame_overlay_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// Scaled frame overlay blend unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SCALED_FRAME_OVERLAY_BLEND_UNIT_DEFINES_SVH
`define SCALED_FRAME_OVERLAY_BLEND_UNIT_DEFINES_SVH

// same-cycle implication
`define SFOB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFOB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sfob_pkg.sv
// ----------------------------------------------------------------------------
// Scaled frame overlay blend package
// Field widths, register indexes, command codes and default sizes.
// ----------------------------------------------------------------------------
package sfob_pkg;

   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int DIM_W       = 13;
   localparam int SCALE_W     = 20;
   localparam int SIZE_W      = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam int MAX_FRAME_WIDTH_DEFAULT  = 256;
   localparam int MAX_FRAME_HEIGHT_DEFAULT = 256;
   localparam int SCALE_FRAC_BITS_DEFAULT  = 12;

   localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(4096);
   localparam logic [DIM_W-1:0]   OFFSET_RESET = '0;
   localparam logic [SIZE_W-1:0]  SIZE_RESET   = SIZE_W'(256);

   localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_BLEND = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_X      = 3'd0,
      CSR_SCALE_Y      = 3'd1,
      CSR_OFFSET_X     = 3'd2,
      CSR_OFFSET_Y     = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5
   } csr_index_type;

endpackage

// File: src/scaled_frame_overlay_blend_unit.sv
// ----------------------------------------------------------------------------
// Scaled frame overlay blend unit
// Seven-stage pipeline: offset, Q scale multiply, frame mapping and bounds,
// store address, frame store access, channel multiplies, blend and output.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns blend
// results in order; load items write the frame store and return nothing. The rate
// is set by the single-port frame store, which serves one load or one blend
// lookup per cycle in the fifth stage, so a blend always sees every load
// accepted before it. The store has no reset: blend only over entries that
// were loaded. Output stalls back up the pipeline; bubbles are filled while
// the output waits.
module scaled_frame_overlay_blend_unit #(
   parameter int MAX_FRAME_WIDTH  = sfob_pkg::MAX_FRAME_WIDTH_DEFAULT,
   parameter int MAX_FRAME_HEIGHT = sfob_pkg::MAX_FRAME_HEIGHT_DEFAULT,
   parameter int SCALE_FRAC_BITS  = sfob_pkg::SCALE_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [sfob_pkg::DIM_W-1:0]          req_column,
   input  logic [sfob_pkg::DIM_W-1:0]          req_row,
   input  logic [sfob_pkg::PIXEL_W-1:0]        req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sfob_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                rsp_covered,
   input  logic                                csr_wr_en,
   input  logic [sfob_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfob_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NS      = 7;
   localparam int DIM_W   = sfob_pkg::DIM_W;
   localparam int PIX_W   = sfob_pkg::PIXEL_W;
   localparam int CH_W    = sfob_pkg::CHAN_W;
   localparam int DIFF_W  = DIM_W + 1;
   localparam int SSCL_W  = sfob_pkg::SCALE_W + 1;
   localparam int PROD_W  = DIFF_W + SSCL_W;
   localparam int MAP_W   = PROD_W - SCALE_FRAC_BITS;
   localparam int DEPTH   = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
   localparam int XW      = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
   localparam int YW      = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MUL_W   = 2 * CH_W;

   localparam logic [DIM_W-1:0] MAXW_D = DIM_W'(MAX_FRAME_WIDTH);
   localparam logic [DIM_W-1:0] MAXH_D = DIM_W'(MAX_FRAME_HEIGHT);
   localparam logic [AW-1:0]    MAXW_A = AW'(MAX_FRAME_WIDTH);

   typedef struct packed {
      logic              cmd;
      logic [DIM_W-1:0]  column;
      logic [DIM_W-1:0]  row;
      logic [DIFF_W-1:0] diff_x;
      logic [DIFF_W-1:0] diff_y;
      logic [PIX_W-1:0]  pixel;
   } s0_type;

   typedef struct packed {
      logic              cmd;
      logic [DIM_W-1:0]  column;
      logic [DIM_W-1:0]  row;
      logic [PROD_W-1:0] prod_x;
      logic [PROD_W-1:0] prod_y;
      logic [PIX_W-1:0]  pixel;
   } s1_type;

   typedef struct packed {
      logic             cmd;
      logic             hit;
      logic [XW-1:0]    x;
      logic [YW-1:0]    y;
      logic [PIX_W-1:0] pixel;
   } s2_type;

   typedef struct packed {
      logic             cmd;
      logic             hit;
      logic [AW-1:0]    addr;
      logic [PIX_W-1:0] pixel;
   } s3_type;

   typedef struct packed {
      logic             hit;
      logic [PIX_W-1:0] pixel;
   } s4_type;

   typedef struct packed {
      logic             hit;
      logic             opaque;
      logic [PIX_W-1:0] frame;
      logic [PIX_W-1:0] pixel;
      logic [MUL_W-1:0] fr;
      logic [MUL_W-1:0] fg;
      logic [MUL_W-1:0] fb;
      logic [MUL_W-1:0] pr;
      logic [MUL_W-1:0] pg;
      logic [MUL_W-1:0] pb;
   } s5_type;

   typedef struct packed {
      logic             covered;
      logic [PIX_W-1:0] pixel;
   } s6_type;

   // configuration
   logic [sfob_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [DIM_W-1:0]             offset_x_ff, offset_y_ff;
   logic [sfob_pkg::SIZE_W-1:0]  frame_width_ff, frame_height_ff;

   // pipeline
   logic [NS-1:0] valid_ff, valid_in, en;
   s0_type s0_ff, s0_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [PIX_W-1:0] frame_store [DEPTH];
   logic [PIX_W-1:0] frame_rd_ff;

   logic signed [SSCL_W-1:0] scale_x_s, scale_y_s;
   logic [DIM_W-1:0]         w_lim, h_lim, fw_ext, fh_ext;
   logic [MAP_W-1:0]         map_x, map_y;
   logic                     in_x, in_y, load_ok;
   logic [CH_W-1:0]          alpha, nalpha;
   logic [MUL_W-1:0]         sum_r, sum_g, sum_b;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff      <= sfob_pkg::SCALE_RESET;
         scale_y_ff      <= sfob_pkg::SCALE_RESET;
         offset_x_ff     <= sfob_pkg::OFFSET_RESET;
         offset_y_ff     <= sfob_pkg::OFFSET_RESET;
         frame_width_ff  <= sfob_pkg::SIZE_RESET;
         frame_height_ff <= sfob_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sfob_pkg::CSR_SCALE_X:      scale_x_ff      <= csr_wdata;
            sfob_pkg::CSR_SCALE_Y:      scale_y_ff      <= csr_wdata;
            sfob_pkg::CSR_OFFSET_X:     offset_x_ff     <= csr_wdata[DIM_W-1:0];
            sfob_pkg::CSR_OFFSET_Y:     offset_y_ff     <= csr_wdata[DIM_W-1:0];
            sfob_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[sfob_pkg::SIZE_W-1:0];
            sfob_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[sfob_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in    = {valid_ff[NS-2:0], req_valid};
      // loads leave the pipeline after the store access
      valid_in[4] = valid_ff[3] && (s3_ff.cmd == sfob_pkg::CMD_BLEND);
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ---------------- stage 0: offset ----------------
   always_comb begin
      s0_in.cmd    = req_command;
      s0_in.column = req_column;
      s0_in.row    = req_row;
      s0_in.pixel  = req_pixel_in;
      s0_in.diff_x = DIFF_W'(req_column) - DIFF_W'(offset_x_ff);
      s0_in.diff_y = DIFF_W'(req_row) - DIFF_W'(offset_y_ff);
   end

   // ---------------- stage 1: scale multiply ----------------
   assign scale_x_s = {1'b0, scale_x_ff};
   assign scale_y_s = {1'b0, scale_y_ff};

   always_comb begin
      s1_in.cmd    = s0_ff.cmd;
      s1_in.column = s0_ff.column;
      s1_in.row    = s0_ff.row;
      s1_in.pixel  = s0_ff.pixel;
      s1_in.prod_x = PROD_W'(PROD_W'($signed(s0_ff.diff_x)) * PROD_W'(scale_x_s));
      s1_in.prod_y = PROD_W'(PROD_W'($signed(s0_ff.diff_y)) * PROD_W'(scale_y_s));
   end

   // ---------------- stage 2: frame mapping and bounds ----------------
   assign fw_ext = DIM_W'(frame_width_ff);
   assign fh_ext = DIM_W'(frame_height_ff);
   assign w_lim  = (fw_ext < MAXW_D) ? fw_ext : MAXW_D;
   assign h_lim  = (fh_ext < MAXH_D) ? fh_ext : MAXH_D;

   assign map_x   = s1_ff.prod_x[PROD_W-1:SCALE_FRAC_BITS];
   assign map_y   = s1_ff.prod_y[PROD_W-1:SCALE_FRAC_BITS];
   assign in_x    = !s1_ff.prod_x[PROD_W-1] && (map_x < MAP_W'(w_lim));
   assign in_y    = !s1_ff.prod_y[PROD_W-1] && (map_y < MAP_W'(h_lim));
   assign load_ok = (s1_ff.column < MAXW_D) && (s1_ff.row < MAXH_D);

   always_comb begin
      s2_in.cmd   = s1_ff.cmd;
      s2_in.pixel = s1_ff.pixel;
      if (s1_ff.cmd == sfob_pkg::CMD_BLEND) begin
         s2_in.hit = in_x && in_y;
         s2_in.x   = map_x[XW-1:0];
         s2_in.y   = map_y[YW-1:0];
      end else begin
         s2_in.hit = load_ok;
         s2_in.x   = s1_ff.column[XW-1:0];
         s2_in.y   = s1_ff.row[YW-1:0];
      end
   end

   // ---------------- stage 3: store address ----------------
   always_comb begin
      s3_in.cmd   = s2_ff.cmd;
      s3_in.hit   = s2_ff.hit;
      s3_in.pixel = s2_ff.pixel;
      s3_in.addr  = AW'(AW'(s2_ff.y) * MAXW_A + AW'(s2_ff.x));
   end

   // ---------------- stage 4: frame store access ----------------
   always_ff @(posedge clock) begin
      if (en[4]) begin
         if (valid_ff[3] && s3_ff.hit && (s3_ff.cmd == sfob_pkg::CMD_LOAD)) begin
            frame_store[s3_ff.addr] <= s3_ff.pixel;
         end
         frame_rd_ff <= frame_store[s3_ff.addr];
      end
   end

   always_comb begin
      s4_in.hit   = s3_ff.hit;
      s4_in.pixel = s3_ff.pixel;
   end

   // ---------------- stage 5: channel multiplies ----------------
   assign alpha  = frame_rd_ff[PIX_W-1 -: CH_W];
   assign nalpha = sfob_pkg::ALPHA_OPAQUE - alpha;

   always_comb begin
      s5_in.hit    = s4_ff.hit;
      s5_in.opaque = (alpha == sfob_pkg::ALPHA_OPAQUE);
      s5_in.frame  = frame_rd_ff;
      s5_in.pixel  = s4_ff.pixel;
      s5_in.fr     = MUL_W'(frame_rd_ff[23:16]) * MUL_W'(alpha);
      s5_in.fg     = MUL_W'(frame_rd_ff[15:8])  * MUL_W'(alpha);
      s5_in.fb     = MUL_W'(frame_rd_ff[7:0])   * MUL_W'(alpha);
      s5_in.pr     = MUL_W'(s4_ff.pixel[23:16]) * MUL_W'(nalpha);
      s5_in.pg     = MUL_W'(s4_ff.pixel[15:8])  * MUL_W'(nalpha);
      s5_in.pb     = MUL_W'(s4_ff.pixel[7:0])   * MUL_W'(nalpha);
   end

   // ---------------- stage 6: blend and output ----------------
   // per-channel sums stay below 2^16, so no carry between channels
   assign sum_r = s5_ff.fr + s5_ff.pr;
   assign sum_g = s5_ff.fg + s5_ff.pg;
   assign sum_b = s5_ff.fb + s5_ff.pb;

   always_comb begin
      s6_in.covered = s5_ff.hit;
      if (!s5_ff.hit) begin
         s6_in.pixel = s5_ff.pixel;
      end else if (s5_ff.opaque) begin
         s6_in.pixel = s5_ff.frame;
      end else begin
         s6_in.pixel = {{CH_W{1'b0}}, sum_r[MUL_W-1:CH_W], sum_g[MUL_W-1:CH_W],
                        sum_b[MUL_W-1:CH_W]};
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= s0_in;
      end
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
      if (en[3]) begin
         s3_ff <= s3_in;
      end
      if (en[4]) begin
         s4_ff <= s4_in;
      end
      if (en[5]) begin
         s5_ff <= s5_in;
      end
      if (en[6]) begin
         s6_ff <= s6_in;
      end
   end

   assign rsp_valid     = valid_ff[NS-1];
   assign rsp_pixel_out = s6_ff.pixel;
   assign rsp_covered   = s6_ff.covered;

endmodule

// File: src/sfob_checker.sv
// ----------------------------------------------------------------------------
// Scaled frame overlay blend checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "scaled_frame_overlay_blend_unit_defines.svh"

module sfob_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sfob_pkg::PIXEL_W-1:0] rsp_pixel_out,
   input logic                         rsp_covered
);

   logic [sfob_pkg::CHAN_W-1:0] top_byte;

   assign top_byte = rsp_pixel_out[sfob_pkg::PIXEL_W-1 -: sfob_pkg::CHAN_W];

   `SFOB_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result after reset")

   `SFOB_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid, "item withdrawn before accept")

   `SFOB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_covered), "stalled item changed")

   `SFOB_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled with output free")

   `SFOB_ASSERT_NOW(a_covered_top_byte, clock, reset, rsp_valid && rsp_covered, top_byte == '0 || top_byte == sfob_pkg::ALPHA_OPAQUE, "covered item with bad top byte")

endmodule

bind scaled_frame_overlay_blend_unit sfob_checker u_sfob_checker (.*);
